// File: rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg: closed tour length shared types
// Item structs, field widths and sequencer states for the tour length core.
// ----------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

  localparam int COORD_W = 16;
  localparam int LEN_W   = 48;
  localparam int CNT_W   = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } ctl_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] tour_length;
    logic [CNT_W-1:0] city_count;
  } ctl_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_EMIT
  } ctl_state_t;

endpackage

`default_nettype wire

// File: rtl/ctl_isqrt.sv
// ----------------------------------------------------------------------------
// ctl_isqrt: iterative integer square root
// Computes floor(sqrt(s * 4^FRAC)), one base-4 digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctl_isqrt #(
  parameter int UB   = 16,
  parameter int FRAC = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*UB:0]         s,
  output logic                       done,
  output logic [UB+FRAC:0]           root
);

  localparam int NIT  = UB + 1 + FRAC;
  localparam int RW   = NIT;
  localparam int REMW = RW + 2;
  localparam int DW   = 2 * NIT;
  localparam int CW   = $clog2(NIT);

  logic [DW-1:0]   d_r;
  logic [REMW-1:0] rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;
  logic [REMW-1:0] rem_nxt;
  logic [RW-1:0]   root_nxt;

  always_comb begin
    rem_sh   = {rem_r[REMW-3:0], d_r[DW-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NIT - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // fraction bits enter as trailing zero digit pairs
      d_r    <= DW'(s) << (2 * FRAC);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      d_r    <= d_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/closed_tour_length_core.sv
// ----------------------------------------------------------------------------
// closed_tour_length_core: closed tour length accumulator
// Sums Euclidean legs of a city stream and closes the tour on the last city.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one city per item (x, y, last). The first
//   city of a tour is only stored. Every later city is accepted, then dx and
//   dy are squared in turn on the shared multiplier, their sum goes through
//   the digit-serial square root (UB = min(COORD_BITS,16)) and the root is
//   added to the tour length as the root unit finishes.
//   A later city flagged last runs a second leg back to the first city
//   through the same root unit, then moves the result into the output
//   register. in_ready is high only while the sequencer is idle.
//   out_valid/out_ready/out_data carry tour_length (FRAC fraction bits,
//   saturating) and city_count (saturating). The output register holds its
//   item while out_ready is low; the next tour may be accepted meanwhile and
//   only its own result waits for the register to free up.
//   Reset (rst_n low, synchronous) clears the sequencer, the tour state and
//   the output valid flag; no tour is in progress afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module closed_tour_length_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC       = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ctl_pkg::ctl_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ctl_pkg::ctl_out_t    out_data
);

  localparam int UB = (COORD_BITS < ctl_pkg::COORD_W) ? COORD_BITS : ctl_pkg::COORD_W;
  localparam int SW = 2 * UB + 1;
  localparam int RW = UB + 1 + FRAC;
  localparam int LW = ctl_pkg::LEN_W;
  localparam int NW = ctl_pkg::CNT_W;

  function automatic logic [UB-1:0] abs_diff(input logic [UB-1:0] a, input logic [UB-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  ctl_pkg::ctl_state_t state_r, state_nxt;

  logic [UB-1:0]   first_x_r, first_x_nxt;
  logic [UB-1:0]   first_y_r, first_y_nxt;
  logic [UB-1:0]   prev_x_r, prev_x_nxt;
  logic [UB-1:0]   prev_y_r, prev_y_nxt;
  logic [UB-1:0]   dx_r, dx_nxt;
  logic [UB-1:0]   dy_r, dy_nxt;
  logic [2*UB-1:0] sq_r, sq_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            last_r, last_nxt;
  logic            close_r, close_nxt;
  logic            out_valid_r, out_valid_nxt;
  ctl_pkg::ctl_out_t out_data_r, out_data_nxt;

  logic            accept;
  logic            slot_free;
  logic            mul_sel_y;
  logic            sq_start;
  logic [UB-1:0]   mul_op;
  logic [2*UB-1:0] prod;
  logic [SW-1:0]   sum_sq;
  logic            sq_done;
  logic [RW-1:0]   leg_root;
  logic [LW:0]     len_sum;
  logic [LW-1:0]   len_sat;
  logic [UB-1:0]   cx;
  logic [UB-1:0]   cy;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cx        = in_data.x[UB-1:0];
  assign cy        = in_data.y[UB-1:0];

  // shared squarer: dx in ST_SQX, dy in ST_SQY
  assign mul_op = mul_sel_y ? dy_r : dx_r;
  assign prod   = (2*UB)'(mul_op) * (2*UB)'(mul_op);
  assign sum_sq = SW'(sq_r) + SW'(prod);

  ctl_isqrt #(
    .UB   (UB),
    .FRAC (FRAC)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .s     (sum_sq),
    .done  (sq_done),
    .root  (leg_root)
  );

  assign len_sum = {1'b0, len_r} + (LW+1)'(leg_root);
  assign len_sat = len_sum[LW] ? ctl_pkg::LEN_MAX : len_sum[LW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctl_pkg::ST_IDLE: begin
        if (accept) begin
          if (count_r == '0) begin
            state_nxt = in_data.last ? ctl_pkg::ST_EMIT : ctl_pkg::ST_IDLE;
          end else begin
            state_nxt = ctl_pkg::ST_SQX;
          end
        end
      end
      ctl_pkg::ST_SQX: state_nxt = ctl_pkg::ST_SQY;
      ctl_pkg::ST_SQY: state_nxt = ctl_pkg::ST_ROOT;
      ctl_pkg::ST_ROOT: begin
        if (sq_done) begin
          if (close_r) begin
            state_nxt = ctl_pkg::ST_SQX;
          end else if (last_r) begin
            state_nxt = ctl_pkg::ST_EMIT;
          end else begin
            state_nxt = ctl_pkg::ST_IDLE;
          end
        end
      end
      ctl_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ctl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctl_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_sel_y = 1'b0;
    sq_start  = 1'b0;
    case (state_r)
      ctl_pkg::ST_IDLE: in_ready = 1'b1;
      ctl_pkg::ST_SQX:  mul_sel_y = 1'b0;
      ctl_pkg::ST_SQY: begin
        mul_sel_y = 1'b1;
        sq_start  = 1'b1;
      end
      ctl_pkg::ST_ROOT: mul_sel_y = 1'b0;
      ctl_pkg::ST_EMIT: mul_sel_y = 1'b0;
      default:          in_ready = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sq_nxt        = sq_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    close_nxt     = close_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (accept) begin
      prev_x_nxt = cx;
      prev_y_nxt = cy;
      last_nxt   = in_data.last;
      if (count_r == '0) begin
        // first city: a one-city tour closes onto itself with length 0
        first_x_nxt = cx;
        first_y_nxt = cy;
        len_nxt     = '0;
        count_nxt   = NW'(1);
        close_nxt   = 1'b0;
      end else begin
        dx_nxt    = abs_diff(prev_x_r, cx);
        dy_nxt    = abs_diff(prev_y_r, cy);
        close_nxt = in_data.last;
        if (count_r != ctl_pkg::CNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end

    if (state_r == ctl_pkg::ST_SQX) begin
      sq_nxt = prod;
    end

    if (state_r == ctl_pkg::ST_ROOT && sq_done) begin
      len_nxt = len_sat;
      if (close_r) begin
        // closing leg from the last city back to the first
        dx_nxt    = abs_diff(prev_x_r, first_x_r);
        dy_nxt    = abs_diff(prev_y_r, first_y_r);
        close_nxt = 1'b0;
      end
    end

    if (state_r == ctl_pkg::ST_EMIT && slot_free) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.tour_length = len_r;
      out_data_nxt.city_count  = count_r;
      len_nxt                  = '0;
      count_nxt                = '0;
      last_nxt                 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctl_pkg::ST_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      last_r      <= 1'b0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      last_r      <= last_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // a city joining a running tour always goes to the squarer
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && count_r != '0 |=> state_r == ctl_pkg::ST_SQX)
    else $error("running tour city did not start a leg");

  // the root unit only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ctl_pkg::ST_ROOT)
    else $error("root finished outside its wait state");

  // emitting a result loads the output register and ends the tour
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ctl_pkg::ST_EMIT && slot_free |=> out_valid_r && count_r == '0)
    else $error("tour result not emitted or tour state not cleared");

  // the closing leg is pending only on a tour's last city
  assert property (@(posedge clk) disable iff (!rst_n)
    close_r |-> last_r)
    else $error("closing leg pending without a last city");
`endif

endmodule

`default_nettype wire
